@@ design/ftrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ftrc_pkg
// Types, tag constants and the reset state shared by the response checker.
// ----------------------------------------------------------------------------
package ftrc_pkg;

   // Tag and sub-tag bytes
   localparam logic [7:0] TAG_FCI       = 8'h6F;
   localparam logic [7:0] TAG_PROP      = 8'hA5;
   localparam logic [7:0] TAG_DIR_HI    = 8'hBF;
   localparam logic [7:0] TAG_DIR_LO    = 8'h0C;
   localparam logic [7:0] TAG_ENTRY     = 8'h61;
   localparam logic [7:0] TAG_ADF_NAME  = 8'h4F;
   localparam logic [7:0] TAG_DISCR     = 8'h73;
   localparam logic [7:0] TAG_SUB       = 8'hDF;
   localparam logic [7:0] TAG_LABEL     = 8'h50;
   localparam logic [7:0] TAG_C0        = 8'hC0;
   localparam logic [7:0] TAG_C2_NONCE  = 8'hC2;
   localparam logic [7:0] TAG_C3_KEY    = 8'hC3;
   localparam logic [7:0] SUB_MAX_VER   = 8'h4D;
   localparam logic [7:0] SUB_MIN_VER   = 8'h6D;
   localparam logic [7:0] SUB_BITMAP    = 8'h62;
   localparam logic [7:0] SUB_KEY       = 8'h6B;
   localparam logic [7:0] SUB_NONCE     = 8'h6E;

   // Expected lengths
   localparam logic [7:0] NONCE_LEN     = 8'h20;
   localparam logic [7:0] KEY_LEN       = 8'h21;
   localparam logic [7:0] VER_LEN       = 8'h02;
   localparam logic [7:0] BITMAP_LEN    = 8'h01;
   localparam logic [7:0] LONG_LEN_MIN  = 8'h80;

   localparam int unsigned VER_W = 13;
   localparam logic [VER_W-1:0] VER_MIN_RESET = 13'd2;

   typedef enum logic [4:0] {
      PH_HDR, PH_LEN0, PH_LEN0X, PH_TAGS, PH_TLEN, PH_TVAL, PH_PROP, PH_A5LEN,
      PH_BF, PH_BF2, PH_BFLEN, PH_DIR, PH_ELEN, PH_AIDTAG, PH_GLEN, PH_GVAL,
      PH_NEXT, PH_BODY, PH_T73LEN, PH_SUB, PH_SUBTAG, PH_MAXLEN, PH_MAXB1,
      PH_MAXB2, PH_MINLEN, PH_MINB1, PH_MINB2, PH_BMLEN, PH_BMVAL, PH_SLEN,
      PH_SVAL, PH_TAIL
   } phase_type;

   typedef enum logic [1:0] {
      TGT_NONE  = 2'd0,
      TGT_NONCE = 2'd1,
      TGT_KEY   = 2'd2
   } target_type;

   typedef enum logic [2:0] {
      VD_OK        = 3'd0,
      VD_BAD_HDR   = 3'd1,
      VD_NO_DIR    = 3'd2,
      VD_NO_ADF    = 3'd3,
      VD_BAD_SUBLEN = 3'd4,
      VD_VERSION   = 3'd5,
      VD_TRUNC     = 3'd6
   } verdict_type;

   // Parser context carried from byte to byte
   typedef struct packed {
      phase_type        phase;
      logic [7:0]       skip_cnt;
      logic [7:0]       entry_rem;
      target_type       target;
      logic [5:0]       cap_pos;
      logic [7:0]       first_ver;
      logic [VER_W-1:0] min_ver;
      logic [VER_W-1:0] max_ver;
      logic             skip_sel;
      verdict_type      err;
   } state_type;

   // One result transfer
   typedef struct packed {
      target_type       capture_kind;
      logic [5:0]       capture_index;
      logic [7:0]       capture_byte;
      logic             done_res;
      verdict_type      verdict;
      logic             skip_select_flag;
      logic [VER_W-1:0] min_version;
      logic [VER_W-1:0] max_version;
   } rsp_type;

   localparam state_type STATE_RESET = '{
      phase:     PH_HDR,
      skip_cnt:  8'd0,
      entry_rem: 8'd0,
      target:    TGT_NONE,
      cap_pos:   6'd0,
      first_ver: 8'd0,
      min_ver:   VER_MIN_RESET,
      max_ver:   '0,
      skip_sel:  1'b0,
      err:       VD_OK
   };

endpackage

@@ design/ftrc_req_if.sv @@
// ----------------------------------------------------------------------------
// ftrc_req_if
// Request channel: one message byte per transfer.
// ----------------------------------------------------------------------------
interface ftrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/ftrc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ftrc_rsp_if
// Response channel: capture report per byte, verdict on the last byte.
// ----------------------------------------------------------------------------
interface ftrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  capture_kind;
   logic [5:0]  capture_index;
   logic [7:0]  capture_byte;
   logic        done_res;
   logic [2:0]  verdict;
   logic        skip_select_flag;
   logic [12:0] min_version;
   logic [12:0] max_version;

   modport source (output valid, output capture_kind, output capture_index,
                   output capture_byte, output done_res, output verdict,
                   output skip_select_flag, output min_version,
                   output max_version, input ready);
   modport sink   (input valid, input capture_kind, input capture_index,
                   input capture_byte, input done_res, input verdict,
                   input skip_select_flag, input min_version,
                   input max_version, output ready);
endinterface

@@ design/ftrc_step.sv @@
// ----------------------------------------------------------------------------
// ftrc_step
// Next parser context and result for one byte: the TLV walk, captures,
// version and bitmap sub-tags, and the verdict on the last byte.
// ----------------------------------------------------------------------------
module ftrc_step (
   input  ftrc_pkg::state_type cur,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output ftrc_pkg::state_type nxt,
   output ftrc_pkg::rsp_type   res
);

   ftrc_pkg::state_type    st;
   ftrc_pkg::rsp_type      r;
   logic [7:0]             b;
   logic [7:0]             rem_dec;
   logic [7:0]             skip_dec;
   logic [ftrc_pkg::VER_W-1:0] ver_val;
   logic                   complete;

   assign b        = data_byte;
   assign rem_dec  = (cur.entry_rem != 8'd0) ? cur.entry_rem - 8'd1 : 8'd0;
   assign skip_dec = cur.skip_cnt - 8'd1;
   // first byte times 16 plus second byte
   assign ver_val  = {1'b0, cur.first_ver, 4'b0000} + {5'b00000, b};

   // Parse one byte
   always_comb begin
      st = cur;
      r  = '0;

      if (cur.err == ftrc_pkg::VD_OK) begin
         case (cur.phase)
            ftrc_pkg::PH_HDR: begin
               if (b == ftrc_pkg::TAG_FCI) begin
                  st.phase = ftrc_pkg::PH_LEN0;
               end else begin
                  st.err   = ftrc_pkg::VD_BAD_HDR;
                  st.phase = ftrc_pkg::PH_TAIL;
               end
            end
            ftrc_pkg::PH_LEN0: begin
               st.phase = (b >= ftrc_pkg::LONG_LEN_MIN) ? ftrc_pkg::PH_LEN0X
                                                        : ftrc_pkg::PH_TAGS;
            end
            ftrc_pkg::PH_LEN0X: st.phase = ftrc_pkg::PH_TAGS;
            ftrc_pkg::PH_TAGS: begin
               if (b == ftrc_pkg::TAG_PROP) begin
                  st.phase = ftrc_pkg::PH_A5LEN;
               end else if (b inside {ftrc_pkg::TAG_LABEL,
                                      [ftrc_pkg::TAG_C0:ftrc_pkg::TAG_C3_KEY]}) begin
                  st.target = (b == ftrc_pkg::TAG_C2_NONCE) ? ftrc_pkg::TGT_NONCE :
                              (b == ftrc_pkg::TAG_C3_KEY)   ? ftrc_pkg::TGT_KEY
                                                            : ftrc_pkg::TGT_NONE;
                  st.phase  = ftrc_pkg::PH_TLEN;
               end else begin
                  st.phase = ftrc_pkg::PH_PROP;
               end
            end
            ftrc_pkg::PH_TLEN, ftrc_pkg::PH_SLEN: begin
               if (cur.phase == ftrc_pkg::PH_SLEN) st.entry_rem = rem_dec;
               // keep the capture only at its expected length
               if ((cur.target == ftrc_pkg::TGT_NONCE && b != ftrc_pkg::NONCE_LEN) ||
                   (cur.target == ftrc_pkg::TGT_KEY && b != ftrc_pkg::KEY_LEN))
                  st.target = ftrc_pkg::TGT_NONE;
               st.cap_pos  = 6'd0;
               st.skip_cnt = b;
               if (cur.phase == ftrc_pkg::PH_SLEN)
                  st.phase = (b == 8'd0) ? ftrc_pkg::PH_SUB : ftrc_pkg::PH_SVAL;
               else
                  st.phase = (b == 8'd0) ? ftrc_pkg::PH_TAGS : ftrc_pkg::PH_TVAL;
            end
            ftrc_pkg::PH_TVAL, ftrc_pkg::PH_SVAL: begin
               if (cur.phase == ftrc_pkg::PH_SVAL) st.entry_rem = rem_dec;
               if (cur.target != ftrc_pkg::TGT_NONE) begin
                  r.capture_kind  = cur.target;
                  r.capture_index = cur.cap_pos;
                  r.capture_byte  = b;
               end
               st.cap_pos  = cur.cap_pos + 6'd1;
               st.skip_cnt = skip_dec;
               if (skip_dec == 8'd0)
                  st.phase = (cur.phase == ftrc_pkg::PH_SVAL) ? ftrc_pkg::PH_SUB
                                                              : ftrc_pkg::PH_TAGS;
            end
            ftrc_pkg::PH_PROP, ftrc_pkg::PH_BF, ftrc_pkg::PH_DIR: begin
               // optional templates fall through to the next expected item
               if (cur.phase == ftrc_pkg::PH_PROP && b == ftrc_pkg::TAG_PROP) begin
                  st.phase = ftrc_pkg::PH_A5LEN;
               end else if (cur.phase != ftrc_pkg::PH_DIR && b == ftrc_pkg::TAG_DIR_HI) begin
                  st.phase = ftrc_pkg::PH_BF2;
               end else if (b == ftrc_pkg::TAG_ENTRY) begin
                  st.phase = ftrc_pkg::PH_ELEN;
               end else begin
                  st.err   = ftrc_pkg::VD_NO_DIR;
                  st.phase = ftrc_pkg::PH_TAIL;
               end
            end
            ftrc_pkg::PH_A5LEN: st.phase = ftrc_pkg::PH_BF;
            ftrc_pkg::PH_BF2: begin
               if (b == ftrc_pkg::TAG_DIR_LO) begin
                  st.phase = ftrc_pkg::PH_BFLEN;
               end else begin
                  st.err   = ftrc_pkg::VD_NO_DIR;
                  st.phase = ftrc_pkg::PH_TAIL;
               end
            end
            ftrc_pkg::PH_BFLEN: st.phase = ftrc_pkg::PH_DIR;
            ftrc_pkg::PH_ELEN: begin
               st.entry_rem = b;
               st.phase     = ftrc_pkg::PH_AIDTAG;
            end
            ftrc_pkg::PH_AIDTAG: begin
               if (b != ftrc_pkg::TAG_ADF_NAME) begin
                  st.err   = ftrc_pkg::VD_NO_ADF;
                  st.phase = ftrc_pkg::PH_TAIL;
               end else begin
                  st.entry_rem = rem_dec;
                  st.phase     = ftrc_pkg::PH_GLEN;
               end
            end
            ftrc_pkg::PH_GLEN: begin
               st.entry_rem = rem_dec;
               st.skip_cnt  = b;
               if (b == 8'd0)
                  st.phase = (rem_dec != 8'd0) ? ftrc_pkg::PH_BODY : ftrc_pkg::PH_NEXT;
               else
                  st.phase = ftrc_pkg::PH_GVAL;
            end
            ftrc_pkg::PH_GVAL: begin
               st.entry_rem = rem_dec;
               st.skip_cnt  = skip_dec;
               if (skip_dec == 8'd0)
                  st.phase = (rem_dec != 8'd0) ? ftrc_pkg::PH_BODY : ftrc_pkg::PH_NEXT;
            end
            ftrc_pkg::PH_NEXT: begin
               st.phase = (b == ftrc_pkg::TAG_ENTRY) ? ftrc_pkg::PH_ELEN : ftrc_pkg::PH_TAIL;
            end
            ftrc_pkg::PH_BODY, ftrc_pkg::PH_SUB: begin
               if (cur.phase == ftrc_pkg::PH_SUB && b == ftrc_pkg::TAG_SUB) begin
                  st.entry_rem = rem_dec;
                  st.phase     = ftrc_pkg::PH_SUBTAG;
               end else if (cur.phase == ftrc_pkg::PH_SUB && cur.entry_rem == 8'd0) begin
                  st.phase = (b == ftrc_pkg::TAG_ENTRY) ? ftrc_pkg::PH_ELEN
                                                        : ftrc_pkg::PH_TAIL;
               end else if (b == ftrc_pkg::TAG_ENTRY) begin
                  // nested entry tag closes the current entry
                  st.phase = ftrc_pkg::PH_ELEN;
               end else if (b == ftrc_pkg::TAG_DISCR) begin
                  st.entry_rem = rem_dec;
                  st.phase     = ftrc_pkg::PH_T73LEN;
               end else begin
                  st.entry_rem = rem_dec;
                  st.phase     = ftrc_pkg::PH_GLEN;
               end
            end
            ftrc_pkg::PH_T73LEN: begin
               st.entry_rem = rem_dec;
               st.phase     = ftrc_pkg::PH_SUB;
            end
            ftrc_pkg::PH_SUBTAG: begin
               st.entry_rem = rem_dec;
               if (b == ftrc_pkg::SUB_MAX_VER) begin
                  st.phase = ftrc_pkg::PH_MAXLEN;
               end else if (b == ftrc_pkg::SUB_MIN_VER) begin
                  st.phase = ftrc_pkg::PH_MINLEN;
               end else if (b == ftrc_pkg::SUB_BITMAP) begin
                  st.phase = ftrc_pkg::PH_BMLEN;
               end else begin
                  st.target = (b == ftrc_pkg::SUB_KEY)   ? ftrc_pkg::TGT_KEY :
                              (b == ftrc_pkg::SUB_NONCE) ? ftrc_pkg::TGT_NONCE
                                                         : ftrc_pkg::TGT_NONE;
                  st.phase  = ftrc_pkg::PH_SLEN;
               end
            end
            ftrc_pkg::PH_MAXLEN, ftrc_pkg::PH_MINLEN: begin
               st.entry_rem = rem_dec;
               if (b != ftrc_pkg::VER_LEN) begin
                  st.err   = ftrc_pkg::VD_BAD_SUBLEN;
                  st.phase = ftrc_pkg::PH_TAIL;
               end else begin
                  st.phase = (cur.phase == ftrc_pkg::PH_MAXLEN) ? ftrc_pkg::PH_MAXB1
                                                                : ftrc_pkg::PH_MINB1;
               end
            end
            ftrc_pkg::PH_MAXB1, ftrc_pkg::PH_MINB1: begin
               st.entry_rem = rem_dec;
               st.first_ver = b;
               st.phase     = (cur.phase == ftrc_pkg::PH_MAXB1) ? ftrc_pkg::PH_MAXB2
                                                                : ftrc_pkg::PH_MINB2;
            end
            ftrc_pkg::PH_MAXB2: begin
               st.entry_rem = rem_dec;
               st.max_ver   = ver_val;
               st.phase     = ftrc_pkg::PH_SUB;
            end
            ftrc_pkg::PH_MINB2: begin
               st.entry_rem = rem_dec;
               st.min_ver   = ver_val;
               st.phase     = ftrc_pkg::PH_SUB;
            end
            ftrc_pkg::PH_BMLEN: begin
               st.entry_rem = rem_dec;
               if (b != ftrc_pkg::BITMAP_LEN) begin
                  st.err   = ftrc_pkg::VD_BAD_SUBLEN;
                  st.phase = ftrc_pkg::PH_TAIL;
               end else begin
                  st.phase = ftrc_pkg::PH_BMVAL;
               end
            end
            ftrc_pkg::PH_BMVAL: begin
               st.entry_rem = rem_dec;
               st.skip_sel  = b[0];
               st.phase     = ftrc_pkg::PH_SUB;
            end
            default: ;
         endcase
      end
   end

   // Message end: verdict, then back to the reset context
   assign complete = (st.phase == ftrc_pkg::PH_TAIL) || (st.phase == ftrc_pkg::PH_NEXT) ||
                     (st.phase == ftrc_pkg::PH_SUB && st.entry_rem == 8'd0);

   always_comb begin
      res = r;
      nxt = st;
      if (last_byte) begin
         res.done_res         = 1'b1;
         res.skip_select_flag = st.skip_sel;
         res.min_version      = st.min_ver;
         res.max_version      = st.max_ver;
         if (st.err != ftrc_pkg::VD_OK)
            res.verdict = st.err;
         else if (!complete)
            res.verdict = ftrc_pkg::VD_TRUNC;
         else if (st.min_ver > 13'd1 || st.max_ver < 13'd1)
            res.verdict = ftrc_pkg::VD_VERSION;
         else
            res.verdict = ftrc_pkg::VD_OK;
         nxt = ftrc_pkg::STATE_RESET;
      end
   end

endmodule

@@ design/fci_tlv_response_checker.sv @@
// ----------------------------------------------------------------------------
// fci_tlv_response_checker
// Byte-serial checker for the TLV layout of a card selection response.
// ----------------------------------------------------------------------------
// The response to a request transfer is in the output register in the cycle after it.
// Throughput: 1 byte per cycle unless stalled, set by the single-byte parser update.
// A held response stalls the input only when the output register is full and not taken.
// Reset: synchronous, active high; parser returns to the expect-header state and the
// output register empties. The context also self-resets after every last byte.
module fci_tlv_response_checker (
   input  logic        clock,
   input  logic        reset,
   ftrc_req_if.sink    req_ch,
   ftrc_rsp_if.source  rsp_ch
);

   ftrc_pkg::state_type state_ff, state_in;
   ftrc_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff;
   logic                req_xfer;

   // Accept whenever the output register is empty or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   ftrc_step u_step (
      .cur       (state_ff),
      .data_byte (req_ch.data_byte),
      .last_byte (req_ch.last_byte),
      .nxt       (state_in),
      .res       (rsp_in)
   );

   // Parser context
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftrc_pkg::STATE_RESET;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.capture_kind     = rsp_ff.capture_kind;
   assign rsp_ch.capture_index    = rsp_ff.capture_index;
   assign rsp_ch.capture_byte     = rsp_ff.capture_byte;
   assign rsp_ch.done_res         = rsp_ff.done_res;
   assign rsp_ch.verdict          = rsp_ff.verdict;
   assign rsp_ch.skip_select_flag = rsp_ff.skip_select_flag;
   assign rsp_ch.min_version      = rsp_ff.min_version;
   assign rsp_ch.max_version      = rsp_ff.max_version;

endmodule
